### rtl/iaf_pkg.sv
// Shared types, codes and constants of the integer to ASCII formatter.
package iaf_pkg;

  // Default character limit and digit buffer depth.
  localparam int MAX_CHARS_DEF = 31;
  localparam int DIG_N         = 24;
  localparam int DIG_IW        = $clog2(DIG_N);
  localparam int VAL_W         = 64;
  localparam int CONV_W        = $clog2(VAL_W);

  // Conversion kinds.
  localparam logic [2:0] FN_SDEC = 3'd0;
  localparam logic [2:0] FN_UDEC = 3'd1;
  localparam logic [2:0] FN_OCT  = 3'd2;
  localparam logic [2:0] FN_HEXL = 3'd3;
  localparam logic [2:0] FN_HEXU = 3'd4;

  // Length codes; every code from LEN_64 upward selects 64 bits.
  localparam logic [2:0] LEN_32 = 3'd0;
  localparam logic [2:0] LEN_8  = 3'd1;
  localparam logic [2:0] LEN_16 = 3'd2;
  localparam logic [2:0] LEN_64 = 3'd3;

  // Flag bit positions.
  localparam int FL_LEFT  = 0;
  localparam int FL_PLUS  = 1;
  localparam int FL_SPACE = 2;
  localparam int FL_ALT   = 3;
  localparam int FL_ZERO  = 4;

  // Characters.
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_A_UP  = 8'h41;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_SET1,
    ST_SET2,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic idle;
    logic conv;
    logic scan;
    logic set1;
    logic set2;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_fire;
    logic is_dec;
    logic conv_done;
    logic scan_done;
    logic out_free;
    logic emit_last;
  } status_t;

endpackage

### rtl/iaf_if.sv
// Valid/ready channel interfaces for input words and output characters.
interface iaf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [63:0] value;
  logic [2:0]  length_code;
  logic [4:0]  flags;
  logic [4:0]  width;
  logic [4:0]  precision;

  modport source (output valid, func, value, length_code, flags, width, precision,
                  input ready);
  modport sink (input valid, func, value, length_code, flags, width, precision,
                output ready);
endinterface

interface iaf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, ch, last, input ready);
  modport sink (input valid, ch, last, output ready);
endinterface

### rtl/iaf_dp.sv
// Datapath: operand capture, binary to BCD conversion, layout and character output.
module iaf_dp #(
  parameter int MAX_CHARS = iaf_pkg::MAX_CHARS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  iaf_in_if.sink           in_if,
  iaf_out_if.source        out_if,
  input  iaf_pkg::cmd_t    cmd,
  output iaf_pkg::status_t sts
);

  localparam int PW = $clog2(MAX_CHARS + 1);
  localparam int DN = iaf_pkg::DIG_N;
  localparam int IW = iaf_pkg::DIG_IW;
  localparam int VW = iaf_pkg::VAL_W;
  localparam int CW = iaf_pkg::CONV_W;
  localparam logic [PW-1:0] MAXC = PW'(MAX_CHARS);

  logic [3:0]    dig_r [DN];
  logic [VW-1:0] mag_r;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] idx_r;
  logic [4:0]    flags_r, w_r, p_r;
  logic          is_dec_r, is_oct_r, is_hex_r, upper_r, sdec_r, neg_r, nz_r;
  logic [PW-1:0] nd_r, td_r, pad_r;
  logic [1:0]    hn_r;
  logic [7:0]    hd0_r, hd1_r;
  logic          zpad_r;
  logic [PW-1:0] b1_r, b2_r, b4_r, b5_r, n_r, pos_r;
  logic [7:0]    ch_r;
  logic          last_r, valid_r;

  // Operand decode at the input.
  logic [2:0]      fn;
  logic [VW-1:0]   mask, mag_m, mag_a;
  logic            msb, neg;
  logic [4*DN-1:0] mag_x;

  always_comb begin
    fn = (in_if.func > iaf_pkg::FN_HEXU) ? iaf_pkg::FN_UDEC : in_if.func;
    case (in_if.length_code)
      iaf_pkg::LEN_32: begin
        mask = {{(VW-32){1'b0}}, {32{1'b1}}};
        msb  = in_if.value[31];
      end
      iaf_pkg::LEN_8: begin
        mask = {{(VW-8){1'b0}}, {8{1'b1}}};
        msb  = in_if.value[7];
      end
      iaf_pkg::LEN_16: begin
        mask = {{(VW-16){1'b0}}, {16{1'b1}}};
        msb  = in_if.value[15];
      end
      default: begin
        mask = {VW{1'b1}};
        msb  = in_if.value[VW-1];
      end
    endcase
    mag_m = in_if.value & mask;
    neg   = (fn == iaf_pkg::FN_SDEC) && msb;
    mag_a = neg ? ((~mag_m + VW'(1)) & mask) : mag_m;
    mag_x = {{(4*DN-VW){1'b0}}, mag_a};
  end

  // Double-dabble step: add three to digits of five or more, then shift.
  logic [3:0] adj [DN];
  logic [3:0] dd  [DN];

  always_comb begin
    for (int k = 0; k < DN; k++) begin
      adj[k] = (dig_r[k] >= 4'd5) ? dig_r[k] + 4'd3 : dig_r[k];
    end
    dd[0] = {adj[0][2:0], mag_r[VW-1]};
    for (int k = 1; k < DN; k++) begin
      dd[k] = {adj[k][2:0], adj[k-1][3]};
    end
  end

  // Layout arithmetic, first stage.
  logic [PW-1:0] cap, pe, td, body, wc, nd;
  logic          zp;

  always_comb begin
    nd   = PW'(idx_r) + PW'(1);
    cap  = (hn_r == 2'd0) ? MAXC - PW'(1) : MAXC - PW'(hn_r);
    pe   = (PW'(p_r) > cap) ? cap : PW'(p_r);
    td   = (nd > pe) ? nd : pe;
    if (flags_r[iaf_pkg::FL_ALT] && is_oct_r && td == nd && nz_r && td < cap) begin
      td = nd + PW'(1);
    end
    wc   = (PW'(w_r) > MAXC) ? MAXC : PW'(w_r);
    body = PW'(hn_r) + td;
    zp   = flags_r[iaf_pkg::FL_ZERO] && !flags_r[iaf_pkg::FL_LEFT] && (p_r == 5'd0);
  end

  // Character at the current position.
  logic [PW-1:0] didx;
  logic [3:0]    dsel;
  logic [7:0]    dch, cur;

  always_comb begin
    didx = b5_r - PW'(1) - pos_r;
    dsel = dig_r[didx[IW-1:0]];
    if (dsel < 4'd10) begin
      dch = iaf_pkg::CH_ZERO + {4'd0, dsel};
    end else begin
      dch = (upper_r ? iaf_pkg::CH_A_UP : iaf_pkg::CH_A_LO) + {4'd0, dsel} - 8'd10;
    end
    if (pos_r < b1_r) begin
      cur = iaf_pkg::CH_SPACE;
    end else if (pos_r < b2_r) begin
      cur = (pos_r == b1_r) ? hd0_r : hd1_r;
    end else if (pos_r < b4_r) begin
      cur = iaf_pkg::CH_ZERO;
    end else if (pos_r < b5_r) begin
      cur = dch;
    end else begin
      cur = iaf_pkg::CH_SPACE;
    end
  end

  logic in_fire, out_free, do_emit;
  assign in_fire  = in_if.valid && in_if.ready;
  assign out_free = !valid_r || out_if.ready;
  assign do_emit  = cmd.emit && out_free;

  // Operand, digit and layout registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      flags_r  <= in_if.flags;
      w_r      <= in_if.width;
      p_r      <= in_if.precision;
      is_dec_r <= (fn == iaf_pkg::FN_SDEC) || (fn == iaf_pkg::FN_UDEC);
      is_oct_r <= fn == iaf_pkg::FN_OCT;
      is_hex_r <= (fn == iaf_pkg::FN_HEXL) || (fn == iaf_pkg::FN_HEXU);
      upper_r  <= fn == iaf_pkg::FN_HEXU;
      sdec_r   <= fn == iaf_pkg::FN_SDEC;
      neg_r    <= neg;
      nz_r     <= mag_a != '0;
      mag_r    <= mag_a;
      cnt_r    <= '0;
      idx_r    <= IW'(DN - 1);
      for (int k = 0; k < DN; k++) begin
        case (fn)
          iaf_pkg::FN_OCT:                    dig_r[k] <= {1'b0, mag_x[3*k +: 3]};
          iaf_pkg::FN_HEXL, iaf_pkg::FN_HEXU: dig_r[k] <= mag_x[4*k +: 4];
          default:                            dig_r[k] <= 4'd0;
        endcase
      end
    end else if (cmd.conv) begin
      for (int k = 0; k < DN; k++) begin
        dig_r[k] <= dd[k];
      end
      mag_r <= {mag_r[VW-2:0], 1'b0};
      cnt_r <= cnt_r + CW'(1);
    end else if (cmd.scan) begin
      if (idx_r != '0 && dig_r[idx_r] == 4'd0) begin
        idx_r <= idx_r - IW'(1);
      end
    end
    if (cmd.scan) begin
      // Head characters: sign or space for signed decimal, 0x prefix for nonzero hex in alternate form.
      if (sdec_r && neg_r) begin
        hn_r <= 2'd1; hd0_r <= iaf_pkg::CH_MINUS;
      end else if (sdec_r && flags_r[iaf_pkg::FL_PLUS]) begin
        hn_r <= 2'd1; hd0_r <= iaf_pkg::CH_PLUS;
      end else if (sdec_r && flags_r[iaf_pkg::FL_SPACE]) begin
        hn_r <= 2'd1; hd0_r <= iaf_pkg::CH_SPACE;
      end else if (is_hex_r && flags_r[iaf_pkg::FL_ALT] && nz_r) begin
        hn_r <= 2'd2; hd0_r <= iaf_pkg::CH_ZERO;
      end else begin
        hn_r <= 2'd0; hd0_r <= iaf_pkg::CH_ZERO;
      end
      hd1_r <= upper_r ? iaf_pkg::CH_X_UP : iaf_pkg::CH_X_LO;
    end
    if (cmd.set1) begin
      nd_r   <= nd;
      td_r   <= td;
      pad_r  <= (wc > body) ? wc - body : '0;
      zpad_r <= zp;
    end
    if (cmd.set2) begin
      b1_r  <= (!flags_r[iaf_pkg::FL_LEFT] && !zpad_r) ? pad_r : '0;
      pos_r <= '0;
    end
    if (do_emit) begin
      pos_r <= pos_r + PW'(1);
    end
  end

  // Segment boundaries follow from the first boundary and are registered along with it.
  logic [PW-1:0] b1c, b2c, b3c, b4c, b5c;
  always_comb begin
    b1c = (!flags_r[iaf_pkg::FL_LEFT] && !zpad_r) ? pad_r : '0;
    b2c = b1c + PW'(hn_r);
    b3c = b2c + (zpad_r ? pad_r : '0);
    b4c = b3c + td_r - nd_r;
    b5c = b4c + nd_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.set2) begin
      b2_r <= b2c;
      b4_r <= b4c;
      b5_r <= b5c;
      n_r  <= b5c + (flags_r[iaf_pkg::FL_LEFT] ? pad_r : '0);
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (do_emit) begin
      valid_r <= 1'b1;
    end else if (out_if.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      ch_r   <= cur;
      last_r <= (pos_r == n_r - PW'(1));
    end
  end

  assign in_if.ready  = cmd.idle;
  assign out_if.valid = valid_r;
  assign out_if.ch    = ch_r;
  assign out_if.last  = last_r;

  assign sts.in_fire   = in_fire;
  assign sts.is_dec    = is_dec_r;
  assign sts.conv_done = cnt_r == {CW{1'b1}};
  assign sts.scan_done = (idx_r == '0) || (dig_r[idx_r] != 4'd0);
  assign sts.out_free  = out_free;
  assign sts.emit_last = pos_r == n_r - PW'(1);

endmodule

### rtl/iaf_ctrl.sv
// Controller state machine that sequences conversion, layout and output.
module iaf_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  iaf_pkg::status_t sts,
  output iaf_pkg::cmd_t    cmd
);

  iaf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iaf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      iaf_pkg::ST_IDLE: if (sts.in_fire) state_nxt = iaf_pkg::ST_CONV;
      iaf_pkg::ST_CONV: begin
        if (!sts.is_dec || sts.conv_done) state_nxt = iaf_pkg::ST_SCAN;
      end
      iaf_pkg::ST_SCAN: if (sts.scan_done) state_nxt = iaf_pkg::ST_SET1;
      iaf_pkg::ST_SET1: state_nxt = iaf_pkg::ST_SET2;
      iaf_pkg::ST_SET2: state_nxt = iaf_pkg::ST_EMIT;
      iaf_pkg::ST_EMIT: begin
        if (sts.out_free && sts.emit_last) state_nxt = iaf_pkg::ST_IDLE;
      end
      default: state_nxt = iaf_pkg::ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      iaf_pkg::ST_IDLE: cmd.idle = 1'b1;
      iaf_pkg::ST_CONV: cmd.conv = sts.is_dec;
      iaf_pkg::ST_SCAN: cmd.scan = 1'b1;
      iaf_pkg::ST_SET1: cmd.set1 = 1'b1;
      iaf_pkg::ST_SET2: cmd.set2 = 1'b1;
      iaf_pkg::ST_EMIT: cmd.emit = 1'b1;
      default:          cmd = '0;
    endcase
  end

endmodule

### rtl/integer_to_ascii_formatter.sv
// Top level of the printf-style integer to ASCII formatter.
// One word is taken at a time. Decimal kinds pass through the
// bit-serial binary to BCD converter, while octal and hex load their digits
// directly; then come a leading-zero scan over the digit buffer, the layout
// states SET1 and SET2, and one output word per cycle for the 1 to MAX_CHARS
// characters while the output does not stall. The output register lets the
// next word be taken while the final character still waits.
module integer_to_ascii_formatter #(
  parameter int MAX_CHARS = iaf_pkg::MAX_CHARS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  iaf_in_if.sink    in_if,
  iaf_out_if.source out_if
);

  iaf_pkg::cmd_t    cmd;
  iaf_pkg::status_t sts;

  iaf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  iaf_dp #(.MAX_CHARS(MAX_CHARS)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cmd    (cmd),
    .sts    (sts)
  );

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the integer to ASCII formatter.
module testbench;

  localparam int MAXC = iaf_pkg::MAX_CHARS_DEF;

  typedef struct {
    logic [2:0]  func;
    logic [63:0] value;
    logic [2:0]  length_code;
    logic [4:0]  flags;
    logic [4:0]  width;
    logic [4:0]  precision;
  } fmt_word_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  iaf_in_if  in_if ();
  iaf_out_if out_if ();

  integer_to_ascii_formatter u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if.sink),
    .out_if(out_if.source)
  );

  fmt_word_t  pending_words[$];
  char_word_t expected_chars[$];
  int         idle_pct = 0;
  int         stall_pct = 0;
  int         errors = 0;
  int         words_sent = 0;
  int         chars_seen = 0;
  bit         drive_done = 1'b0;

  // Clock with a period of 8 ns.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Append the characters that one word formats to.
  function automatic void format_word(fmt_word_t wd);
    logic [2:0]  kind;
    int          nbits, radix, ndig, tdig, head, cap, prec, wid, body, pad;
    logic [63:0] mask, mag;
    logic        neg, nonzero, upper, left, alt, zpad;
    logic [7:0]  digs[24];
    logic [7:0]  hdr[3];
    logic [7:0]  line[$];
    int          d;
    kind = wd.func > iaf_pkg::FN_HEXU ? iaf_pkg::FN_UDEC : wd.func;
    radix = (kind == iaf_pkg::FN_SDEC || kind == iaf_pkg::FN_UDEC) ? 10 :
            (kind == iaf_pkg::FN_OCT ? 8 : 16);
    upper = kind == iaf_pkg::FN_HEXU;
    left = wd.flags[iaf_pkg::FL_LEFT];
    alt = wd.flags[iaf_pkg::FL_ALT];
    prec = wd.precision;
    zpad = wd.flags[iaf_pkg::FL_ZERO] && !left && prec == 0;
    nbits = wd.length_code == iaf_pkg::LEN_32 ? 32 : wd.length_code == iaf_pkg::LEN_8 ? 8 :
            wd.length_code == iaf_pkg::LEN_16 ? 16 : 64;
    mask = nbits == 64 ? '1 : ((64'd1 << nbits) - 64'd1);
    mag = wd.value & mask;
    neg = 1'b0;
    if (kind == iaf_pkg::FN_SDEC && mag[nbits-1]) begin
      neg = 1'b1;
      mag = (~mag + 64'd1) & mask;
    end
    nonzero = mag != 0;
    ndig = 0;
    do begin
      d = int'(mag % radix);
      digs[ndig++] = d < 10 ? 8'(iaf_pkg::CH_ZERO + d) :
                     8'((upper ? iaf_pkg::CH_A_UP : iaf_pkg::CH_A_LO) + d - 10);
      mag = mag / radix;
    end while (mag != 0 && ndig < 24);
    head = 0;
    if (kind == iaf_pkg::FN_SDEC) begin
      if (neg) hdr[head++] = iaf_pkg::CH_MINUS;
      else if (wd.flags[iaf_pkg::FL_PLUS]) hdr[head++] = iaf_pkg::CH_PLUS;
      else if (wd.flags[iaf_pkg::FL_SPACE]) hdr[head++] = iaf_pkg::CH_SPACE;
    end
    if (alt && radix == 16 && nonzero) begin
      hdr[head++] = iaf_pkg::CH_ZERO;
      hdr[head++] = upper ? iaf_pkg::CH_X_UP : iaf_pkg::CH_X_LO;
    end
    cap = MAXC - 1;
    if (MAXC - head < cap) cap = MAXC - head;
    if (prec > cap) prec = cap;
    tdig = ndig > prec ? ndig : prec;
    if (alt && radix == 8 && tdig == ndig && digs[ndig-1] != iaf_pkg::CH_ZERO && tdig < cap)
      tdig = ndig + 1;
    wid = wd.width > MAXC ? MAXC : wd.width;
    body = head + tdig;
    pad = wid > body ? wid - body : 0;
    if (!left && !zpad) repeat (pad) line.push_back(iaf_pkg::CH_SPACE);
    for (int i = 0; i < head; i++) line.push_back(hdr[i]);
    if (zpad) repeat (pad) line.push_back(iaf_pkg::CH_ZERO);
    repeat (tdig - ndig) line.push_back(iaf_pkg::CH_ZERO);
    for (int i = ndig; i > 0; i--) line.push_back(digs[i-1]);
    if (left) repeat (pad) line.push_back(iaf_pkg::CH_SPACE);
    foreach (line[i]) expected_chars.push_back('{line[i], i == line.size() - 1});
  endfunction

  // Accept seen at the rising edge; ready has usually dropped by the falling edge.
  logic in_taken;
  always @(posedge clk) in_taken <= in_if.valid && in_if.ready;

  // Driver: offers the next queued word, idling at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_taken) begin
      if (in_if.valid) begin
        format_word(pending_words.pop_front());
        words_sent++;
      end
      if (pending_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_if.valid       <= 1'b1;
        in_if.func        <= pending_words[0].func;
        in_if.value       <= pending_words[0].value;
        in_if.length_code <= pending_words[0].length_code;
        in_if.flags       <= pending_words[0].flags;
        in_if.width       <= pending_words[0].width;
        in_if.precision   <= pending_words[0].precision;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    out_if.ready <= $urandom_range(99) >= stall_pct;
  end

  // Monitor: checks each accepted character against the oldest expectation.
  always @(posedge clk) begin
    char_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      chars_seen++;
      if (expected_chars.size() == 0) begin
        $error("unexpected character %h", out_if.ch);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (out_if.ch !== want.ch) begin
          $error("ch: expected %h actual %h", want.ch, out_if.ch);
          errors++;
        end
        if (out_if.last !== want.last) begin
          $error("last: expected %b actual %b", want.last, out_if.last);
          errors++;
        end
      end
    end
  end

  function automatic fmt_word_t random_word();
    fmt_word_t wd;
    wd.func = $urandom_range(99) < 90 ? 3'($urandom_range(4)) : 3'($urandom_range(7));
    case ($urandom_range(3))
      0: wd.value = {$urandom, $urandom};
      1: wd.value = 64'($urandom_range(300));
      2: wd.value = {32'hFFFFFFFF, $urandom} | 64'hFF00;
      default: wd.value = {$urandom, $urandom} >> $urandom_range(63);
    endcase
    wd.length_code = 3'($urandom_range(7));
    wd.flags = 5'($urandom_range(31));
    wd.width = $urandom_range(99) < 60 ? 5'($urandom_range(12)) : 5'($urandom_range(31));
    wd.precision = $urandom_range(99) < 60 ? 5'd0 : 5'($urandom_range(31));
    return wd;
  endfunction

  // Stimulus and end of run.
  initial begin
    fmt_word_t wd;
    int        phase;
    in_if.valid = 1'b0;
    in_if.func = '0;
    in_if.value = '0;
    in_if.length_code = '0;
    in_if.flags = '0;
    in_if.width = '0;
    in_if.precision = '0;
    out_if.ready = 1'b0;
    // Directed words: extremes, every kind, sign, prefix and padding cases.
    pending_words.push_back('{iaf_pkg::FN_SDEC, 64'd0, iaf_pkg::LEN_32, 5'd0, 5'd0, 5'd0});
    pending_words.push_back('{iaf_pkg::FN_SDEC, 64'h80000000, iaf_pkg::LEN_32,
                              5'd0, 5'd0, 5'd0});
    pending_words.push_back('{iaf_pkg::FN_SDEC, 64'h8000000000000000, iaf_pkg::LEN_64,
                              5'd2, 5'd31, 5'd0});
    pending_words.push_back('{iaf_pkg::FN_SDEC, 64'h7F, iaf_pkg::LEN_8, 5'd2, 5'd6, 5'd0});
    pending_words.push_back('{iaf_pkg::FN_SDEC, 64'hFF80, iaf_pkg::LEN_16, 5'd16, 5'd9, 5'd0});
    pending_words.push_back('{iaf_pkg::FN_SDEC, 64'd42, iaf_pkg::LEN_32, 5'd4, 5'd0, 5'd5});
    pending_words.push_back('{iaf_pkg::FN_SDEC, 64'd42, iaf_pkg::LEN_32, 5'd6, 5'd8, 5'd0});
    pending_words.push_back('{iaf_pkg::FN_UDEC, '1, 3'd7, 5'd0, 5'd0, 5'd0});
    pending_words.push_back('{iaf_pkg::FN_UDEC, '1, iaf_pkg::LEN_32, 5'd6, 5'd31, 5'd31});
    pending_words.push_back('{iaf_pkg::FN_OCT, 64'd8, iaf_pkg::LEN_32, 5'd8, 5'd0, 5'd0});
    pending_words.push_back('{iaf_pkg::FN_OCT, 64'd0, iaf_pkg::LEN_32, 5'd8, 5'd4, 5'd0});
    pending_words.push_back('{iaf_pkg::FN_OCT, 64'd8, iaf_pkg::LEN_32, 5'd8, 5'd0, 5'd4});
    pending_words.push_back('{iaf_pkg::FN_OCT, '1, 3'd4, 5'd8, 5'd0, 5'd30});
    pending_words.push_back('{iaf_pkg::FN_HEXL, 64'hDEADBEEF, iaf_pkg::LEN_32,
                              5'd8, 5'd12, 5'd0});
    pending_words.push_back('{iaf_pkg::FN_HEXU, 64'hDEADBEEF, iaf_pkg::LEN_32,
                              5'd24, 5'd14, 5'd0});
    pending_words.push_back('{iaf_pkg::FN_HEXU, 64'd0, iaf_pkg::LEN_32, 5'd8, 5'd0, 5'd0});
    pending_words.push_back('{iaf_pkg::FN_HEXL, '1, 3'd5, 5'd9, 5'd31, 5'd31});
    pending_words.push_back('{iaf_pkg::FN_HEXL, 64'hAB, iaf_pkg::LEN_8, 5'd1, 5'd7, 5'd0});
    pending_words.push_back('{iaf_pkg::FN_HEXL, 64'hAB, iaf_pkg::LEN_8, 5'd17, 5'd7, 5'd3});
    pending_words.push_back('{3'd5, 64'd123, iaf_pkg::LEN_32, 5'd0, 5'd0, 5'd0});
    pending_words.push_back('{3'd7, 64'd0, 3'd6, 5'd31, 5'd31, 5'd0});
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // Random words in four phases of input idling and output stalling.
    for (phase = 0; phase < 4; phase++) begin
      idle_pct  = phase == 1 || phase == 3 ? (phase == 3 ? 20 : 45) : 0;
      stall_pct = phase == 2 || phase == 3 ? (phase == 3 ? 20 : 45) : 0;
      repeat (90) pending_words.push_back(random_word());
      wait (pending_words.size() == 0 && !in_if.valid);
    end
    wait (expected_chars.size() == 0);
    repeat (200) @(posedge clk);
    $display("Formatted %0d words, %0d characters checked, all kinds and flags.",
             words_sent, chars_seen);
    if (errors == 0 && expected_chars.size() == 0)
      $display("integer_to_ascii_formatter: match");
    else
      $display("integer_to_ascii_formatter: mismatch");
    $finish;
  end

  // Timeout guard.
  initial begin
    #20ms;
    $display("integer_to_ascii_formatter: mismatch");
    $finish;
  end

endmodule

### integer_to_ascii_formatter.f
rtl/iaf_pkg.sv
rtl/iaf_if.sv
rtl/iaf_dp.sv
rtl/iaf_ctrl.sv
rtl/integer_to_ascii_formatter.sv
tb/testbench.sv
